@@ hdl/ibe_pkg.sv @@
// shared constants and item types for the i2c master byte engine
`default_nettype none
package ibe_pkg;

	localparam int OP_W = 3;
	localparam int HALF_W = 16;
	localparam int BYTE_W = 8;

	localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
	localparam logic [OP_W-1:0] OP_START = 3'd1;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd2;
	localparam logic [OP_W-1:0] OP_WRITE = 3'd3;
	localparam logic [OP_W-1:0] OP_READ  = 3'd4;

	localparam logic [HALF_W-1:0] HALF_PERIOD_RESET = 16'd50;
	localparam int QUEUE_DEPTH = 2;

	// classified tick as it waits for the engine
	typedef struct packed {
		logic              is_cmd;
		logic [OP_W-1:0]   cmd;
		logic [BYTE_W-1:0] tx_byte;
		logic              ack_to_send;
		logic              sda_in;
	} front_item_t;

	// one result item per tick
	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] rx_byte;
		logic              ack_received;
	} result_t;

endpackage
`default_nettype wire

@@ hdl/i2c_master_byte_engine_top.sv @@
// top level of the i2c master byte engine
`default_nettype none
// I2C master pin engine. Every input item is one timing tick carrying the
// sampled SDA level and, while the engine is idle, an optional command
// (start, stop, write byte, read byte); every tick yields exactly one result
// item with the SCL/SDA levels, SDA direction, busy/done flags, the last
// received byte and the last write ACK. Each bus phase lasts
// half_period_ticks ticks (0 acts as 1). Ticks are accepted one per clock
// while the front queue has room: the front end classifies and queues them,
// the phase engine retires one queued tick per cycle, while the result queue
// has room, into that queue as its result item, so throughput is one item
// per clock while the consumer keeps popping. full rises only when the
// consumer stops popping and both queues fill up.
// The config channel is always ready; write it only while no ticks are in
// flight.
module i2c_master_byte_engine_top #(
	parameter int QUEUE_DEPTH = ibe_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// tick input
	input  wire logic        push,
	output logic             full,
	input  wire logic [2:0]  op,
	input  wire logic [7:0]  tx_byte,
	input  wire logic        ack_to_send,
	input  wire logic        sda_in,
	// result output
	input  wire logic        pop,
	output logic             empty,
	output logic             scl_level,
	output logic             sda_level,
	output logic             sda_drive,
	output logic             busy_res,
	output logic             done_res,
	output logic [7:0]       rx_byte,
	output logic             ack_received,
	// half period register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);
	import ibe_pkg::*;

	logic [HALF_W-1:0] half_q;
	logic              item_valid;
	logic              item_take;
	front_item_t       item;
	result_t           result;

	// half period register, always writable
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			half_q <= cfg_data;
		end
	end

	// front: classify and queue ticks
	ibe_front #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.op(op),
		.tx_byte(tx_byte),
		.ack_to_send(ack_to_send),
		.sda_in(sda_in),
		.item_valid(item_valid),
		.item(item),
		.item_take(item_take)
	);

	// back: phase engine and result queue
	ibe_back #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.half_period(half_q),
		.item_valid(item_valid),
		.item(item),
		.item_take(item_take),
		.pop(pop),
		.empty(empty),
		.result(result)
	);

	// result fields out to the ports
	assign scl_level = result.scl_level;
	assign sda_level = result.sda_level;
	assign sda_drive = result.sda_drive;
	assign busy_res = result.busy_res;
	assign done_res = result.done_res;
	assign rx_byte = result.rx_byte;
	assign ack_received = result.ack_received;

endmodule
`default_nettype wire

@@ hdl/ibe_fifo.sv @@
// small flop-based fifo with simultaneous push and pop
`default_nettype none
module ibe_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wr_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rd_data
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic do_push, do_pop;

	assign full = (count_q == FULL_CNT);
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

@@ hdl/ibe_front.sv @@
// front end: takes ticks, classifies the op and queues them for the engine
`default_nettype none
module ibe_front #(
	parameter int QUEUE_DEPTH = ibe_pkg::QUEUE_DEPTH
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	output logic                           full,
	input  wire logic [ibe_pkg::OP_W-1:0]  op,
	input  wire logic [ibe_pkg::BYTE_W-1:0] tx_byte,
	input  wire logic                      ack_to_send,
	input  wire logic                      sda_in,
	output logic                           item_valid,
	output ibe_pkg::front_item_t           item,
	input  wire logic                      item_take
);
	import ibe_pkg::*;

	front_item_t cls;
	logic q_empty;

	always_comb begin
		cls.is_cmd = 1'b0;
		cls.cmd = OP_TICK;
		cls.tx_byte = tx_byte;
		cls.ack_to_send = ack_to_send;
		cls.sda_in = sda_in;
		case (op) inside
			[OP_START:OP_READ]: begin
				cls.is_cmd = 1'b1;
				cls.cmd = op;
			end
			default: begin
				// tick only and undefined codes
				cls.is_cmd = 1'b0;
			end
		endcase
	end

	ibe_fifo #(
		.WIDTH($bits(front_item_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.wr_data(cls),
		.full(full),
		.pop(item_take),
		.empty(q_empty),
		.rd_data(item)
	);

	assign item_valid = !q_empty;

endmodule
`default_nettype wire

@@ hdl/ibe_back.sv @@
// back end: bus phase engine, one tick per cycle while its result queue has room
`default_nettype none
module ibe_back #(
	parameter int QUEUE_DEPTH = ibe_pkg::QUEUE_DEPTH
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [ibe_pkg::HALF_W-1:0]  half_period,
	input  wire logic                        item_valid,
	input  wire ibe_pkg::front_item_t        item,
	output logic                             item_take,
	input  wire logic                        pop,
	output logic                             empty,
	output ibe_pkg::result_t                 result
);
	import ibe_pkg::*;

	localparam logic [3:0] PH_IDLE    = 4'd0;
	localparam logic [3:0] PH_START_A = 4'd1;
	localparam logic [3:0] PH_START_B = 4'd2;
	localparam logic [3:0] PH_START_C = 4'd3;
	localparam logic [3:0] PH_START_D = 4'd4;
	localparam logic [3:0] PH_STOP_A  = 4'd5;
	localparam logic [3:0] PH_STOP_B  = 4'd6;
	localparam logic [3:0] PH_STOP_C  = 4'd7;
	localparam logic [3:0] PH_WBIT_HI = 4'd8;
	localparam logic [3:0] PH_WBIT_LO = 4'd9;
	localparam logic [3:0] PH_RBIT_HI = 4'd10;
	localparam logic [3:0] PH_RBIT_LO = 4'd11;
	localparam logic [3:0] PH_ABIT_HI = 4'd12;
	localparam logic [3:0] PH_ABIT_LO = 4'd13;

	logic [3:0]        phase_q, phase_d;
	logic [OP_W-1:0]   cmd_q, cmd_d;
	logic [HALF_W-1:0] tick_q, tick_d;
	logic [3:0]        bit_q, bit_d;
	logic [BYTE_W-1:0] shift_q, shift_d;
	logic              ackh_q, ackh_d;
	logic              scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
	logic [BYTE_W-1:0] rx_q, rx_d;
	logic              acks_q, acks_d;
	logic              done;
	logic [HALF_W-1:0] half_eff;
	logic              outq_full;
	result_t           res;

	assign half_eff = (half_period == '0) ? HALF_W'(1) : half_period;
	assign item_take = item_valid && !outq_full;

	always_comb begin
		phase_d = phase_q;
		cmd_d = cmd_q;
		tick_d = tick_q;
		bit_d = bit_q;
		shift_d = shift_q;
		ackh_d = ackh_q;
		scl_d = scl_q;
		sda_d = sda_q;
		drv_d = drv_q;
		rx_d = rx_q;
		acks_d = acks_q;
		done = 1'b0;

		// command load on an idle tick
		if (phase_q == PH_IDLE && item.is_cmd) begin
			cmd_d = item.cmd;
			tick_d = '0;
			bit_d = '0;
			shift_d = (item.cmd == OP_WRITE) ? item.tx_byte : '0;
			ackh_d = item.ack_to_send;
			case (item.cmd)
				OP_START: phase_d = PH_START_A;
				OP_STOP:  phase_d = PH_STOP_A;
				OP_WRITE: phase_d = PH_WBIT_HI;
				default:  phase_d = PH_RBIT_HI;
			endcase
		end

		if (phase_d != PH_IDLE) begin
			// pins of the current phase
			case (phase_d)
				PH_START_A, PH_START_B: {scl_d, sda_d, drv_d} = 3'b111;
				PH_START_C: {scl_d, sda_d, drv_d} = 3'b101;
				PH_START_D: {scl_d, sda_d, drv_d} = 3'b001;
				PH_STOP_A, PH_STOP_B: {scl_d, sda_d, drv_d} = 3'b101;
				PH_STOP_C: {scl_d, sda_d, drv_d} = 3'b111;
				PH_WBIT_HI: {scl_d, sda_d, drv_d} = {1'b1, shift_d[BYTE_W-1], 1'b1};
				PH_WBIT_LO: {scl_d, sda_d, drv_d} = {1'b0, shift_d[BYTE_W-1], 1'b1};
				PH_RBIT_HI: {scl_d, sda_d, drv_d} = 3'b110;
				PH_RBIT_LO: {scl_d, sda_d, drv_d} = 3'b010;
				PH_ABIT_HI: {scl_d, sda_d, drv_d} = {1'b1, ackh_d, 1'b1};
				PH_ABIT_LO: {scl_d, sda_d, drv_d} = {1'b0, ackh_d, 1'b1};
				default: ;
			endcase

			tick_d = tick_d + HALF_W'(1);
			if (tick_d >= half_eff) begin
				tick_d = '0;
				case (phase_d)
					PH_START_A: phase_d = PH_START_B;
					PH_START_B: phase_d = PH_START_C;
					PH_START_C: phase_d = PH_START_D;
					PH_STOP_A:  phase_d = PH_STOP_B;
					PH_STOP_B:  phase_d = PH_STOP_C;
					PH_WBIT_HI: phase_d = PH_WBIT_LO;
					PH_WBIT_LO: begin
						shift_d = {shift_d[BYTE_W-2:0], 1'b0};
						bit_d = bit_d + 4'd1;
						phase_d = (bit_d >= 4'd8) ? PH_RBIT_HI : PH_WBIT_HI;
					end
					PH_RBIT_HI: begin
						if (cmd_d == OP_WRITE) begin
							acks_d = item.sda_in;
						end else begin
							shift_d = {shift_d[BYTE_W-2:0], item.sda_in};
						end
						phase_d = PH_RBIT_LO;
					end
					PH_RBIT_LO: begin
						if (cmd_d == OP_WRITE) begin
							phase_d = PH_IDLE;
							done = 1'b1;
						end else begin
							bit_d = bit_d + 4'd1;
							if (bit_d >= 4'd8) begin
								rx_d = shift_d;
								phase_d = PH_ABIT_HI;
							end else begin
								phase_d = PH_RBIT_HI;
							end
						end
					end
					PH_ABIT_HI: phase_d = PH_ABIT_LO;
					default: begin
						// last phase of start, stop and read
						phase_d = PH_IDLE;
						done = 1'b1;
					end
				endcase
			end
		end

		res.scl_level = scl_d;
		res.sda_level = drv_d ? sda_d : 1'b1;
		res.sda_drive = drv_d;
		res.busy_res = (phase_d != PH_IDLE);
		res.done_res = done;
		res.rx_byte = rx_d;
		res.ack_received = acks_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cmd_q <= OP_TICK;
			tick_q <= '0;
			bit_q <= '0;
			shift_q <= '0;
			ackh_q <= 1'b0;
			scl_q <= 1'b1;
			sda_q <= 1'b1;
			drv_q <= 1'b1;
			rx_q <= '0;
			acks_q <= 1'b0;
		end else if (item_take) begin
			phase_q <= phase_d;
			cmd_q <= cmd_d;
			tick_q <= tick_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			ackh_q <= ackh_d;
			scl_q <= scl_d;
			sda_q <= sda_d;
			drv_q <= drv_d;
			rx_q <= rx_d;
			acks_q <= acks_d;
		end
	end

	ibe_fifo #(
		.WIDTH($bits(result_t)),
		.DEPTH(QUEUE_DEPTH)
	) u_outq (
		.clk(clk),
		.arst_n(arst_n),
		.push(item_take),
		.wr_data(res),
		.full(outq_full),
		.pop(pop),
		.empty(empty),
		.rd_data(result)
	);

endmodule
`default_nettype wire

@@ sim/i2c_master_byte_engine_top_tb.sv @@
// testbench for the i2c master byte engine: directed table, then random ticks checked by a predictor
`timescale 1ns / 100ps
module i2c_master_byte_engine_top_tb;
	import ibe_pkg::*;

	// run length and pacing
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int TICKS_PER_SWEEP = 135;
	localparam int SWEEP_N = 6;
	localparam int HALF_SWEEP [SWEEP_N] = '{1, 2, 0, 4, 1, 3};
	localparam int SETTLE_CYCLES = 4;
	localparam int WIDE_TICKS = 24;

	// op codes the block treats as a plain tick
	localparam logic [OP_W-1:0] OP_UNDEF_LO = 3'd5;
	localparam logic [OP_W-1:0] OP_UNDEF_HI = 3'd7;

	// bus phases of the engine, in the order a command walks them
	typedef enum logic [3:0] {
		BP_IDLE,
		BP_START_A, BP_START_B, BP_START_C, BP_START_D,
		BP_STOP_A, BP_STOP_B, BP_STOP_C,
		BP_WBIT_HI, BP_WBIT_LO,
		BP_RBIT_HI, BP_RBIT_LO,
		BP_ABIT_HI, BP_ABIT_LO
	} bus_phase_t;

	// one row of the directed table: either a half period write or a run of
	// identical ticks, with an optional fixed expectation
	typedef struct packed {
		logic              wr_half;
		logic [HALF_W-1:0] half;
		logic [OP_W-1:0]   op;
		logic [BYTE_W-1:0] tx;
		logic              ak;
		logic              sda;
		logic [7:0]        reps;
		logic              pinned;
		result_t           exp;
	} dir_row_t;

	// pins after reset, bus driven high, nothing received yet
	localparam result_t IDLE_PINS = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};
	localparam result_t NO_EXP = '0;

	localparam int DIR_N = 21;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// tick only right after reset: idle pins held
		'{1'b0, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b1, 8'd1, 1'b1, IDLE_PINS},
		// undefined op while idle acts as a tick
		'{1'b0, 16'd0, OP_UNDEF_HI, 8'hff, 1'b1, 1'b0, 8'd1, 1'b1, IDLE_PINS},
		// zero half period behaves as one tick per phase
		'{1'b1, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_START, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_EXP},
		// commands while busy are dropped
		'{1'b0, 16'd0, OP_STOP, 8'h00, 1'b0, 1'b1, 8'd3, 1'b0, NO_EXP},
		// all-ones byte, slave does not acknowledge
		'{1'b0, 16'd0, OP_WRITE, 8'hff, 1'b0, 1'b1, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_READ, 8'h00, 1'b1, 1'b1, 8'd17, 1'b0, NO_EXP},
		// all-zeros byte, slave acknowledges
		'{1'b0, 16'd0, OP_WRITE, 8'h00, 1'b1, 1'b0, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b0, 8'd17, 1'b0, NO_EXP},
		// read all ones, send nack, sda goes back to output in ack slot
		'{1'b0, 16'd0, OP_READ, 8'h00, 1'b1, 1'b1, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b1, 8'd17, 1'b0, NO_EXP},
		// read all zeros, send ack
		'{1'b0, 16'd0, OP_READ, 8'hff, 1'b0, 1'b0, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_UNDEF_LO, 8'h00, 1'b1, 1'b0, 8'd17, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_UNDEF_LO, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_EXP},
		// stop drives sda again after the released read bits
		'{1'b0, 16'd0, OP_STOP, 8'h00, 1'b0, 1'b1, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b1, 8'd2, 1'b0, NO_EXP},
		// longer phases
		'{1'b1, 16'd3, OP_TICK, 8'h00, 1'b0, 1'b0, 8'd0, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_WRITE, 8'ha5, 1'b0, 1'b0, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_START, 8'h00, 1'b0, 1'b1, 8'd53, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_READ, 8'h00, 1'b1, 1'b1, 8'd1, 1'b0, NO_EXP},
		'{1'b0, 16'd0, OP_TICK, 8'h00, 1'b0, 1'b0, 8'd53, 1'b0, NO_EXP}
	};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              push;
	logic              full;
	logic [OP_W-1:0]   op;
	logic [BYTE_W-1:0] tx_byte;
	logic              ack_to_send;
	logic              sda_in;
	logic              pop;
	logic              empty;
	logic              scl_level;
	logic              sda_level;
	logic              sda_drive;
	logic              busy_res;
	logic              done_res;
	logic [BYTE_W-1:0] rx_byte;
	logic              ack_received;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [HALF_W-1:0] cfg_data;

	// predicted engine state, mirrors what the block should hold
	bus_phase_t        ph;
	logic [OP_W-1:0]   cur_cmd;
	logic [HALF_W-1:0] tick_cnt;
	logic [3:0]        bit_cnt;
	logic [BYTE_W-1:0] shreg;
	logic              ack_lvl;
	logic              scl_q, sda_q, drv_q;
	logic [BYTE_W-1:0] last_rx;
	logic              last_ack;
	logic [HALF_W-1:0] half_cfg;

	// pin results still owed by the block, oldest first
	result_t           pin_results_q [$];
	int                err_count = 0;
	int                cycle_count = 0;
	// steady mode turns off idling on both sides for the widest half period run
	bit                steady = 1'b0;
	int                push_calm = 0;
	int                pop_calm = 0;
	int                pop_hold = 0;

	i2c_master_byte_engine_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.op           (op),
		.tx_byte      (tx_byte),
		.ack_to_send  (ack_to_send),
		.sda_in       (sda_in),
		.pop          (pop),
		.empty        (empty),
		.scl_level    (scl_level),
		.sda_level    (sda_level),
		.sda_drive    (sda_drive),
		.busy_res     (busy_res),
		.done_res     (done_res),
		.rx_byte      (rx_byte),
		.ack_received (ack_received),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// gap length: mostly none or short, a few long, and calm stretches with none
	function automatic int pick_gap(inout int calm);
		int r;
		if (steady)
			return 0;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 5) begin
			calm = $urandom_range(20, 80);
			return 0;
		end
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// advance the predicted engine by one tick and return the pins it shows
	function automatic result_t bus_step(input logic [OP_W-1:0] o, input logic [BYTE_W-1:0] t,
			input logic a, input logic s);
		result_t r;
		logic [HALF_W-1:0] h;
		logic fin;
		h = (half_cfg == '0) ? 16'd1 : half_cfg;
		fin = 1'b0;
		// a command is only taken while idle; its tick is the first of phase one
		if (ph == BP_IDLE && o >= OP_START && o <= OP_READ) begin
			cur_cmd = o;
			tick_cnt = '0;
			bit_cnt = '0;
			shreg = (o == OP_WRITE) ? t : 8'h00;
			ack_lvl = a;
			case (o)
				OP_START: ph = BP_START_A;
				OP_STOP: ph = BP_STOP_A;
				OP_WRITE: ph = BP_WBIT_HI;
				default: ph = BP_RBIT_HI;
			endcase
		end
		if (ph != BP_IDLE) begin
			case (ph)
				BP_START_A, BP_START_B: {scl_q, sda_q, drv_q} = 3'b111;
				BP_START_C: {scl_q, sda_q, drv_q} = 3'b101;
				BP_START_D: {scl_q, sda_q, drv_q} = 3'b001;
				BP_STOP_A, BP_STOP_B: {scl_q, sda_q, drv_q} = 3'b101;
				BP_STOP_C: {scl_q, sda_q, drv_q} = 3'b111;
				BP_WBIT_HI: {scl_q, sda_q, drv_q} = {1'b1, shreg[7], 1'b1};
				BP_WBIT_LO: {scl_q, sda_q, drv_q} = {1'b0, shreg[7], 1'b1};
				BP_RBIT_HI: {scl_q, sda_q, drv_q} = 3'b110;
				BP_RBIT_LO: {scl_q, sda_q, drv_q} = 3'b010;
				BP_ABIT_HI: {scl_q, sda_q, drv_q} = {1'b1, ack_lvl, 1'b1};
				BP_ABIT_LO: {scl_q, sda_q, drv_q} = {1'b0, ack_lvl, 1'b1};
				default: ;
			endcase
			tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= h) begin
				tick_cnt = '0;
				case (ph)
					BP_START_A: ph = BP_START_B;
					BP_START_B: ph = BP_START_C;
					BP_START_C: ph = BP_START_D;
					BP_STOP_A: ph = BP_STOP_B;
					BP_STOP_B: ph = BP_STOP_C;
					BP_WBIT_HI: ph = BP_WBIT_LO;
					BP_WBIT_LO: begin
						shreg = {shreg[6:0], 1'b0};
						bit_cnt = bit_cnt + 4'd1;
						// after the eighth bit the ack slot is read like a data bit
						ph = (bit_cnt >= 4'd8) ? BP_RBIT_HI : BP_WBIT_HI;
					end
					BP_RBIT_HI: begin
						// sda sampled on the last tick of scl high
						if (cur_cmd == OP_WRITE)
							last_ack = s;
						else
							shreg = {shreg[6:0], s};
						ph = BP_RBIT_LO;
					end
					BP_RBIT_LO: begin
						if (cur_cmd == OP_WRITE) begin
							ph = BP_IDLE;
							fin = 1'b1;
						end else begin
							bit_cnt = bit_cnt + 4'd1;
							if (bit_cnt >= 4'd8) begin
								last_rx = shreg;
								ph = BP_ABIT_HI;
							end else begin
								ph = BP_RBIT_HI;
							end
						end
					end
					BP_ABIT_HI: ph = BP_ABIT_LO;
					default: begin
						ph = BP_IDLE;
						fin = 1'b1;
					end
				endcase
			end
		end
		r.scl_level = scl_q;
		r.sda_level = drv_q ? sda_q : 1'b1;
		r.sda_drive = drv_q;
		r.busy_res = (ph != BP_IDLE);
		r.done_res = fin;
		r.rx_byte = last_rx;
		r.ack_received = last_ack;
		return r;
	endfunction

	// offer one tick, wait for the block to take it, then record what it owes
	task automatic put_tick(input logic [OP_W-1:0] o, input logic [BYTE_W-1:0] t, input logic a,
			input logic s, input bit pinned, input result_t pinned_exp);
		int gap;
		result_t r;
		gap = pick_gap(push_calm);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		op <= o;
		tx_byte <= t;
		ack_to_send <= a;
		sda_in <= s;
		do @(posedge clk); while (full);
		r = bus_step(o, t, a, s);
		// rows with a typed expectation stand on their own
		pin_results_q.push_back(pinned ? pinned_exp : r);
	endtask

	// run plain ticks until the engine is idle, drain, then write the half period
	task automatic write_half(input logic [HALF_W-1:0] v);
		while (ph != BP_IDLE)
			put_tick(OP_TICK, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_EXP);
		push <= 1'b0;
		while (pin_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		half_cfg = v;
	endtask

	// compare one popped item with the oldest expectation, field by field
	task automatic check_pins(input result_t want, input result_t got);
		if (got.scl_level !== want.scl_level) begin
			$error("scl_level expected %0d got %0d", want.scl_level, got.scl_level);
			err_count++;
		end
		if (got.sda_level !== want.sda_level) begin
			$error("sda_level expected %0d got %0d", want.sda_level, got.sda_level);
			err_count++;
		end
		if (got.sda_drive !== want.sda_drive) begin
			$error("sda_drive expected %0d got %0d", want.sda_drive, got.sda_drive);
			err_count++;
		end
		if (got.busy_res !== want.busy_res) begin
			$error("busy_res expected %0d got %0d", want.busy_res, got.busy_res);
			err_count++;
		end
		if (got.done_res !== want.done_res) begin
			$error("done_res expected %0d got %0d", want.done_res, got.done_res);
			err_count++;
		end
		if (got.rx_byte !== want.rx_byte) begin
			$error("rx_byte expected 0x%02h got 0x%02h", want.rx_byte, got.rx_byte);
			err_count++;
		end
		if (got.ack_received !== want.ack_received) begin
			$error("ack_received expected %0d got %0d", want.ack_received, got.ack_received);
			err_count++;
		end
	endtask

	// result side: sample before the edge updates, so no race with the block
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pin_results_q.size() == 0) begin
				$error("result item popped with nothing expected");
				err_count++;
			end else begin
				check_pins(pin_results_q.pop_front(),
					'{scl_level, sda_level, sda_drive, busy_res, done_res, rx_byte, ack_received});
			end
		end
	end

	// consumer: pop held high, dropped for random stretches
	initial begin
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pop_hold > 0) begin
				pop <= 1'b0;
				pop_hold--;
			end else begin
				pop <= 1'b1;
				pop_hold = pick_gap(pop_calm);
			end
		end
	end

	// watchdog on total cycles
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// stimulus
	initial begin
		int k;
		int n;
		logic [OP_W-1:0] o;
		dir_row_t row;
		// known levels on every input from time zero
		arst_n = 1'b0;
		push = 1'b0;
		op = OP_TICK;
		tx_byte = '0;
		ack_to_send = 1'b0;
		sda_in = 1'b1;
		cfg_valid = 1'b0;
		cfg_data = '0;
		// predictor reset state
		ph = BP_IDLE;
		cur_cmd = OP_TICK;
		tick_cnt = '0;
		bit_cnt = '0;
		shreg = '0;
		ack_lvl = 1'b0;
		{scl_q, sda_q, drv_q} = 3'b111;
		last_rx = '0;
		last_ack = 1'b0;
		half_cfg = HALF_PERIOD_RESET;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (k = 0; k < DIR_N; k++) begin
			row = DIR_ROWS[k];
			if (row.wr_half)
				write_half(row.half);
			else
				repeat (row.reps)
					put_tick(row.op, row.tx, row.ak, row.sda, row.pinned, row.exp);
		end

		// random sweeps over several short half periods; idle ticks mostly start
		// a new command so the engine spends its time inside whole transfers
		for (k = 0; k < SWEEP_N; k++) begin
			write_half((k == 4) ? 16'($urandom_range(1, 6)) : 16'(HALF_SWEEP[k]));
			for (n = 0; n < TICKS_PER_SWEEP; n++) begin
				if (ph == BP_IDLE) begin
					case ($urandom_range(0, 9))
						0: o = OP_TICK;
						1: o = 3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI));
						default: o = 3'($urandom_range(OP_START, OP_READ));
					endcase
				end else begin
					// anything offered while busy is dropped
					o = 3'($urandom_range(0, 7));
				end
				put_tick(o, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_EXP);
			end
		end

		// widest half period: the first ticks of a stop condition without idling
		steady = 1'b1;
		write_half(16'hffff);
		put_tick(OP_STOP, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0, NO_EXP);
		repeat (WIDE_TICKS)
			put_tick(OP_TICK, 8'h00, 1'b0, 1'($urandom), 1'b0, NO_EXP);
		push <= 1'b0;

		// drain and settle
		while (pin_results_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
